>>> src/ftt_pkg.sv
package ftt_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam logic [30:0] FRAME_MAX = 31'h7FFF_FFFF;

  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_ADD_ABS     = 3'd1;
  localparam logic [2:0] CMD_ADD_DELAY   = 3'd2;
  localparam logic [2:0] CMD_ADD_PER     = 3'd3;
  localparam logic [2:0] CMD_ADD_PER_LIM = 3'd4;

  localparam logic [2:0] KIND_FIRE     = 3'd0;
  localparam logic [2:0] KIND_DONE     = 3'd1;
  localparam logic [2:0] KIND_ACCEPTED = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_ZERO_PER = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        oneshot;
    logic [30:0] target;
    logic [15:0] period;
    logic [15:0] phase;
    logic [31:0] fire_index;
    logic [15:0] remaining;
    logic [7:0]  tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic in_ready;
    logic latch;
    logic ins_go;
    logic scan_step;
    logic done_go;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic in_insert;
    logic empty;
    logic out_free;
    logic need_out;
    logic last_slot;
  } dp_stat_t;

endpackage

>>> src/frame_task_timer_table.sv
// Channel  Direction  tdata (low bit up)                                tuser  tlast
// s_axis   in         current_frame, frame_value, period, repeat_count,  cmd    -
//                     tag, zero pad
// m_axis   out        fired_tag, argument                               kind   last
//
// A tick visits the slot memory one live entry per cycle, unless the output stalls,
// through its single read port while survivors are written back compacted. Reset is
// synchronous and empties the table. A stalled output holds the scan only on a slot
// that fires.
module frame_task_timer_table #(
  parameter int SLOTS = ftt_pkg::SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // current_frame, frame_value, period, repeat_count, tag
  input  logic [2:0]   s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // fired_tag, argument
  output logic [2:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast
);

  ftt_pkg::ctrl_cmd_t cmd;
  ftt_pkg::dp_stat_t  stat;

  ftt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .stat    (stat),
    .cmd     (cmd)
  );

  ftt_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

  assign s_axis_tready = cmd.in_ready;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_go || cmd.done_go || (cmd.scan_step && stat.need_out)) |-> stat.out_free)
    else $error("result pushed while output register is occupied");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ftt_pkg::KIND_FIRE)) |-> !m_axis_tlast)
    else $error("fire result marked as last");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !(cmd.scan_step || cmd.ins_go || cmd.done_go))
    else $error("input ready while a request is in progress");
`endif

endmodule

>>> src/ftt_ram.sv
module ftt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/ftt_ctrl.sv
module ftt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ftt_pkg::dp_stat_t stat,
  output ftt_pkg::ctrl_cmd_t cmd
);

  ftt_pkg::state_t state;
  ftt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ftt_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (stat.in_tick) begin
            state_next = stat.empty ? ftt_pkg::ST_DONE : ftt_pkg::ST_SCAN;
          end else if (stat.in_insert) begin
            state_next = ftt_pkg::ST_INSERT;
          end
        end
      end
      ftt_pkg::ST_INSERT: begin
        if (stat.out_free) begin
          cmd.ins_go = 1'b1;
          state_next = ftt_pkg::ST_IDLE;
        end
      end
      ftt_pkg::ST_SCAN: begin
        if (!stat.need_out || stat.out_free) begin
          cmd.scan_step = 1'b1;
          if (stat.last_slot) begin
            state_next = ftt_pkg::ST_DONE;
          end
        end
      end
      ftt_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.done_go = 1'b1;
          state_next = ftt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ftt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/ftt_dp.sv
module ftt_dp #(
  parameter int SLOTS = ftt_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  ftt_pkg::ctrl_cmd_t  cmd,
  output ftt_pkg::dp_stat_t   stat,
  input  logic [103:0]        in_data,
  input  logic [2:0]          in_user,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [39:0]         out_data,
  output logic [2:0]          out_user,
  output logic                out_last
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [2:0]  cmd_q;
  logic [30:0] now_q;
  logic [30:0] fv_q;
  logic [15:0] period_q;
  logic [15:0] reps_q;
  logic [7:0]  tag_q;

  logic [IW-1:0] rptr;
  logic [CW-1:0] wptr;
  logic [CW-1:0] live_count;

  logic [IW-1:0]           rd_addr;
  logic [ftt_pkg::ENTRY_W-1:0] rd_raw;
  ftt_pkg::entry_t         cur;
  ftt_pkg::entry_t         upd;
  ftt_pkg::entry_t         ins_entry;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  ftt_pkg::entry_t         wr_entry;

  logic        fire;
  logic        remove;
  logic [15:0] phase_inc;
  logic        is_per;
  logic        zero_per;
  logic        full;
  logic        ins_ok;
  logic [2:0]  ins_kind;
  logic [31:0] sum;
  logic        push;
  logic [2:0]  push_kind;
  logic [7:0]  push_tag;
  logic [31:0] push_arg;
  logic        push_last;

  ftt_ram #(
    .WIDTH(ftt_pkg::ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  assign cur = ftt_pkg::entry_t'(rd_raw);

  always_comb begin
    upd       = cur;
    phase_inc = cur.phase + 16'd1;
    if (cur.oneshot) begin
      fire   = (cur.target <= now_q);
      remove = fire;
    end else begin
      fire   = (cur.phase == 16'd0);
      remove = fire && (cur.remaining == 16'd1);
      if (fire) begin
        upd.fire_index = cur.fire_index + 32'd1;
        if (cur.remaining != 16'd0) begin
          upd.remaining = cur.remaining - 16'd1;
        end
      end
      upd.phase = (phase_inc >= cur.period) ? 16'd0 : phase_inc;
    end
  end

  always_comb begin
    is_per   = (cmd_q == ftt_pkg::CMD_ADD_PER) || (cmd_q == ftt_pkg::CMD_ADD_PER_LIM);
    zero_per = is_per && (period_q == 16'd0);
    full     = (live_count == CW'(SLOTS));
    ins_ok   = !zero_per && !full;
    ins_kind = zero_per ? ftt_pkg::KIND_ZERO_PER :
               (full ? ftt_pkg::KIND_FULL : ftt_pkg::KIND_ACCEPTED);
    sum      = {1'b0, now_q} + {1'b0, fv_q};
    ins_entry            = '0;
    ins_entry.oneshot    = !is_per;
    ins_entry.target     = (cmd_q == ftt_pkg::CMD_ADD_ABS) ? fv_q :
                           (sum[31] ? ftt_pkg::FRAME_MAX : sum[30:0]);
    ins_entry.period     = period_q;
    ins_entry.remaining  = (cmd_q == ftt_pkg::CMD_ADD_PER_LIM) ? reps_q : 16'd0;
    ins_entry.tag        = tag_q;
  end

  always_comb begin
    if (cmd.ins_go) begin
      wr_en    = ins_ok;
      wr_addr  = live_count[IW-1:0];
      wr_entry = ins_entry;
    end else begin
      wr_en    = cmd.scan_step && !remove;
      wr_addr  = wptr[IW-1:0];
      wr_entry = upd;
    end
    if (cmd.latch) begin
      rd_addr = '0;
    end else if (cmd.scan_step) begin
      rd_addr = rptr + IW'(1);
    end else begin
      rd_addr = rptr;
    end
  end

  always_comb begin
    push      = cmd.ins_go || cmd.done_go || (cmd.scan_step && fire);
    push_kind = ftt_pkg::KIND_FIRE;
    push_tag  = 8'd0;
    push_arg  = 32'd0;
    push_last = 1'b1;
    if (cmd.ins_go) begin
      push_kind = ins_kind;
    end else if (cmd.done_go) begin
      push_kind = ftt_pkg::KIND_DONE;
    end else begin
      push_tag  = cur.tag;
      push_arg  = cur.oneshot ? 32'd0 : cur.fire_index;
      push_last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q    <= in_user;
      now_q    <= in_data[30:0];
      fv_q     <= in_data[61:31];
      period_q <= in_data[77:62];
      reps_q   <= in_data[93:78];
      tag_q    <= in_data[101:94];
    end
    if (push) begin
      out_user <= push_kind;
      out_data <= {push_arg, push_tag};
      out_last <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      live_count <= '0;
      rptr       <= '0;
      wptr       <= '0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.latch) begin
        rptr <= '0;
        wptr <= '0;
      end else if (cmd.scan_step) begin
        rptr <= rptr + IW'(1);
        if (!remove) begin
          wptr <= wptr + CW'(1);
        end
      end
      if (cmd.ins_go && ins_ok) begin
        live_count <= live_count + CW'(1);
      end else if (cmd.done_go) begin
        live_count <= wptr;
      end
    end
  end

  always_comb begin
    stat.in_tick   = (in_user == ftt_pkg::CMD_TICK);
    stat.in_insert = (in_user == ftt_pkg::CMD_ADD_ABS) ||
                     (in_user == ftt_pkg::CMD_ADD_DELAY) ||
                     (in_user == ftt_pkg::CMD_ADD_PER) ||
                     (in_user == ftt_pkg::CMD_ADD_PER_LIM);
    stat.empty     = (live_count == '0);
    stat.out_free  = !out_valid || out_ready;
    stat.need_out  = fire;
    stat.last_slot = ((CW'(rptr) + CW'(1)) == live_count);
  end

endmodule

>>> dv/frame_task_timer_table_tb.sv
`timescale 1ns / 1ps

module frame_task_timer_table_tb;

  localparam int TABLE_SLOTS = ftt_pkg::SLOTS_DEFAULT;
  localparam int RANDOM_REQUESTS = 340;
  localparam int HOLD_OFF_AFTER = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic [31:0] argument;
    logic        last;
  } timer_event_t;

  class timer_table_tracker;
    ftt_pkg::entry_t slots[$];
    timer_event_t    expected_events[$];
    int mismatches;
    int fires;
    int ticks;
    int fulls;
    int zero_periods;
    int ignored;

    function void push_event(logic [2:0] kind, logic [7:0] tag, logic [31:0] argument,
                             logic last);
      timer_event_t ev;
      ev.kind = kind;
      ev.tag = tag;
      ev.argument = argument;
      ev.last = last;
      expected_events.push_back(ev);
    endfunction

    function void add_slot(logic oneshot, logic [30:0] target, logic [15:0] period,
                           logic [15:0] remaining, logic [7:0] tag);
      ftt_pkg::entry_t e;
      if (!oneshot && period == 16'd0) begin
        zero_periods++;
        push_event(ftt_pkg::KIND_ZERO_PER, 8'd0, 32'd0, 1'b1);
      end else if (slots.size() >= TABLE_SLOTS) begin
        fulls++;
        push_event(ftt_pkg::KIND_FULL, 8'd0, 32'd0, 1'b1);
      end else begin
        e.oneshot = oneshot;
        e.target = target;
        e.period = period;
        e.phase = 16'd0;
        e.fire_index = 32'd0;
        e.remaining = remaining;
        e.tag = tag;
        slots.push_back(e);
        push_event(ftt_pkg::KIND_ACCEPTED, 8'd0, 32'd0, 1'b1);
      end
    endfunction

    // Removed slots are deleted in place, so the slots behind them are still
    // visited by the same tick.
    function void run_tick(logic [30:0] now);
      int i;
      ftt_pkg::entry_t e;
      logic drop;
      i = 0;
      while (i < slots.size()) begin
        e = slots[i];
        drop = 1'b0;
        if (e.oneshot) begin
          if (e.target <= now) begin
            fires++;
            push_event(ftt_pkg::KIND_FIRE, e.tag, 32'd0, 1'b0);
            drop = 1'b1;
          end
        end else begin
          if (e.phase == 16'd0) begin
            fires++;
            push_event(ftt_pkg::KIND_FIRE, e.tag, e.fire_index, 1'b0);
            e.fire_index = e.fire_index + 32'd1;
            if (e.remaining != 16'd0) begin
              e.remaining = e.remaining - 16'd1;
              if (e.remaining == 16'd0) drop = 1'b1;
            end
          end
          if (int'(e.phase) + 1 >= int'(e.period)) e.phase = 16'd0;
          else e.phase = e.phase + 16'd1;
        end
        if (drop) begin
          slots.delete(i);
        end else begin
          slots[i] = e;
          i++;
        end
      end
      ticks++;
      push_event(ftt_pkg::KIND_DONE, 8'd0, 32'd0, 1'b1);
    endfunction

    function void apply_request(logic [2:0] cmd, logic [30:0] now, logic [30:0] fv,
                                logic [15:0] period, logic [15:0] reps, logic [7:0] tag);
      logic [31:0] sum;
      case (cmd)
        ftt_pkg::CMD_TICK: run_tick(now);
        ftt_pkg::CMD_ADD_ABS: add_slot(1'b1, fv, 16'd0, 16'd0, tag);
        ftt_pkg::CMD_ADD_DELAY: begin
          sum = {1'b0, now} + {1'b0, fv};
          if (sum > {1'b0, ftt_pkg::FRAME_MAX}) sum = {1'b0, ftt_pkg::FRAME_MAX};
          add_slot(1'b1, sum[30:0], 16'd0, 16'd0, tag);
        end
        ftt_pkg::CMD_ADD_PER: add_slot(1'b0, 31'd0, period, 16'd0, tag);
        ftt_pkg::CMD_ADD_PER_LIM: add_slot(1'b0, 31'd0, period, reps, tag);
        default: ignored++;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PRINT_LIMIT)
        $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [2:0] kind, logic [39:0] data, logic last);
      timer_event_t want;
      if (expected_events.size() == 0) begin
        report("result with nothing pending, kind", {29'd0, kind}, 32'd0);
      end else begin
        want = expected_events.pop_front();
        if (kind !== want.kind) report("kind", {29'd0, kind}, {29'd0, want.kind});
        if (data[7:0] !== want.tag) report("fired_tag", {24'd0, data[7:0]}, {24'd0, want.tag});
        if (data[39:8] !== want.argument) report("argument", data[39:8], want.argument);
        if (last !== want.last) report("last", {31'd0, last}, {31'd0, want.last});
      end
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  timer_table_tracker tracker = new();
  int requests_sent = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int stall_cycles;
  logic [30:0] frame_now = 31'd1000;

  frame_task_timer_table #(.SLOTS(TABLE_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 12);
  endfunction

  task automatic send_request(input logic [2:0] cmd, input logic [30:0] now,
                              input logic [30:0] fv, input logic [15:0] period,
                              input logic [15:0] reps, input logic [7:0] tag);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {2'b00, tag, reps, period, fv, now};
    s_axis_tuser <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    tracker.apply_request(cmd, now, fv, period, reps, tag);
    requests_sent++;
  endtask

  // Mostly near-future one-shots and short limited periodic tasks, so slots
  // come and go; unlimited tasks are kept rare since they never leave.
  task automatic random_request(input logic insert_heavy, output logic counted);
    int pick;
    int sel;
    logic [2:0]  cmd;
    logic [30:0] now;
    logic [30:0] fv;
    logic [15:0] period;
    logic [15:0] reps;
    logic [7:0]  tag;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    now = 31'($urandom);
    fv = 31'($urandom);
    period = 16'($urandom);
    reps = 16'($urandom);
    tag = 8'($urandom);
    if (pick < 3) begin
      cmd = 3'($urandom_range(5, 7));
    end else if (pick < (insert_heavy ? 35 : 70)) begin
      cmd = ftt_pkg::CMD_TICK;
      frame_now = frame_now + 31'($urandom_range(0, 3));
      if ($urandom_range(0, 39) != 0) now = frame_now;
    end else if (sel < 30) begin
      cmd = ftt_pkg::CMD_ADD_ABS;
      if ($urandom_range(0, 15) != 0) fv = frame_now + 31'($urandom_range(0, 20));
    end else if (sel < 60) begin
      cmd = ftt_pkg::CMD_ADD_DELAY;
      if ($urandom_range(0, 15) != 0) begin
        now = frame_now;
        fv = 31'($urandom_range(0, 20));
      end
    end else begin
      cmd = (sel < 62) ? ftt_pkg::CMD_ADD_PER : ftt_pkg::CMD_ADD_PER_LIM;
      if ($urandom_range(0, 19) == 0) period = 16'd0;
      else if ($urandom_range(0, 15) != 0) period = 16'($urandom_range(1, 6));
      if ($urandom_range(0, 19) == 0) reps = 16'd0;
      else if ($urandom_range(0, 15) != 0) reps = 16'($urandom_range(1, 4));
    end
    send_request(cmd, now, fv, period, reps, tag);
    counted = (cmd <= ftt_pkg::CMD_ADD_PER_LIM);
  endtask

  initial begin
    bit held;
    int gap;
    held = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && requests_sent >= HOLD_OFF_AFTER) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      tracker.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("** frame_task_timer_table: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int counted_requests;
    logic counted;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= ftt_pkg::CMD_TICK;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(ftt_pkg::CMD_TICK, 31'd0, 31'd0, 16'd0, 16'd0, 8'd0);
    send_request(ftt_pkg::CMD_ADD_PER, 31'd0, 31'd0, 16'd0, 16'd0, 8'hFF);
    send_request(ftt_pkg::CMD_ADD_PER_LIM, 31'd0, 31'd0, 16'd0, 16'd7, 8'h01);
    send_request(ftt_pkg::CMD_ADD_ABS, 31'd0, ftt_pkg::FRAME_MAX, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(ftt_pkg::CMD_ADD_DELAY, ftt_pkg::FRAME_MAX, ftt_pkg::FRAME_MAX, 16'd0,
                 16'd0, 8'h00);
    send_request(ftt_pkg::CMD_ADD_DELAY, 31'd100, 31'd5, 16'd0, 16'd0, 8'h5A);
    send_request(ftt_pkg::CMD_ADD_ABS, 31'd0, 31'd0, 16'd0, 16'd0, 8'h11);
    send_request(ftt_pkg::CMD_ADD_PER_LIM, 31'd0, 31'd0, 16'd1, 16'd2, 8'h22);
    send_request(ftt_pkg::CMD_ADD_PER_LIM, 31'd0, 31'd0, 16'd3, 16'd0, 8'h33);
    send_request(ftt_pkg::CMD_ADD_PER, 31'd0, 31'd0, 16'hFFFF, 16'd0, 8'h44);
    send_request(ftt_pkg::CMD_TICK, 31'd0, 31'd0, 16'd0, 16'd0, 8'd0);
    send_request(ftt_pkg::CMD_TICK, 31'd104, 31'd0, 16'd0, 16'd0, 8'd0);
    send_request(ftt_pkg::CMD_TICK, 31'd105, 31'd0, 16'd0, 16'd0, 8'd0);
    send_request(3'd5, ftt_pkg::FRAME_MAX, ftt_pkg::FRAME_MAX, 16'hFFFF, 16'hFFFF, 8'hFF);
    for (int k = 0; k < 12; k++)
      send_request(k[0] ? ftt_pkg::CMD_ADD_ABS : ftt_pkg::CMD_ADD_DELAY, 31'd200,
                   31'(300 + k), 16'd0, 16'd0, 8'(8'h80 + k));
    send_request(ftt_pkg::CMD_ADD_DELAY, 31'd200, 31'd1, 16'd0, 16'd0, 8'h9F);
    send_request(ftt_pkg::CMD_ADD_PER_LIM, 31'd0, 31'd0, 16'd0, 16'd1, 8'hA0);
    send_request(ftt_pkg::CMD_TICK, ftt_pkg::FRAME_MAX, 31'd0, 16'd0, 16'd0, 8'd0);

    counted_requests = 0;
    while (counted_requests < RANDOM_REQUESTS) begin
      random_request(((counted_requests / 40) % 2) == 0, counted);
      if (counted) counted_requests++;
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d unknown commands) with one long output hold-off.",
             requests_sent, tracker.ignored);
    $display("Seen %0d ticks, %0d firings, %0d table-full and %0d zero-period answers.",
             tracker.ticks, tracker.fires, tracker.fulls, tracker.zero_periods);
    if (tracker.mismatches == 0) begin
      $display("** frame_task_timer_table: PASSED **");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("** frame_task_timer_table: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/ftt_pkg.sv
src/ftt_ram.sv
src/ftt_ctrl.sv
src/ftt_dp.sv
src/frame_task_timer_table.sv
dv/frame_task_timer_table_tb.sv
